// File: design/slb_pkg.sv
// Shared constants and types for the script lexer byte stream block.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package slb_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF   = 20;

  localparam int unsigned KIND_BITS   = 4;
  // A byte closes at most a held token, emits its own and ends the source.
  localparam int unsigned SLOT_COUNT  = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SEPARATOR = 4'd0,
    KIND_ASSIGN    = 4'd1,
    KIND_METHOD    = 4'd2,
    KIND_OPERATOR  = 4'd3,
    KIND_CONDITION = 4'd4,
    KIND_NUMBER    = 4'd5,
    KIND_OTHER     = 4'd6,
    KIND_LINE_END  = 4'd7,
    KIND_CODE_END  = 4'd8
  } token_kind_e;

endpackage

`default_nettype wire

// File: design/slb_front.sv
// Lexer front end: accepts source bytes, tracks held tokens and words, and
// builds one bundle of up to three tokens per byte. Depends on slb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slb_front #(
  parameter int unsigned OFFSET_BITS = slb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = slb_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = slb_pkg::LINE_BITS_DEF,
  localparam int unsigned TOKEN_BITS =
    1 + slb_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  input  wire logic [7:0]                               code_byte_i,
  input  wire logic                                     end_of_code_i,
  input  wire logic                                     full_i,
  output logic                                          push_o,
  output logic [slb_pkg::SLOT_COUNT*TOKEN_BITS-1:0]     bundle_o
);

  typedef enum logic [2:0] {
    PEND_NONE, PEND_WORD, PEND_GT, PEND_LT, PEND_EQ, PEND_BANG, PEND_MINUS, PEND_STAR
  } pend_e;

  typedef enum logic [2:0] {
    NS_START, NS_INT, NS_DOT, NS_FRAC, NS_DEAD
  } shape_e;

  localparam logic [3:0] KW_START       = 4'd0;
  localparam logic [3:0] KW_USE_FIRST   = 4'd1;
  localparam logic [3:0] KW_USE_DONE    = 4'd3;
  localparam logic [3:0] KW_PRINT_FIRST = 4'd4;
  localparam logic [3:0] KW_PRINT_DONE  = 4'd8;
  localparam logic [3:0] KW_INPUT_FIRST = 4'd9;
  localparam logic [3:0] KW_INPUT_DONE  = 4'd13;
  localparam logic [3:0] KW_DEAD        = 4'd14;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Byte expected after each keyword match step; zero where no step follows.
  function automatic logic [7:0] kw_expect(input logic [3:0] k);
    logic [7:0] e;
    unique case (k)
      4'd1:    e = "s";
      4'd2:    e = "e";
      4'd4:    e = "r";
      4'd5:    e = "i";
      4'd6:    e = "n";
      4'd7:    e = "t";
      4'd9:    e = "n";
      4'd10:   e = "p";
      4'd11:   e = "u";
      4'd12:   e = "t";
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] b);
    logic [7:0] e;
    logic [3:0] r;
    e = kw_expect(k);
    if (k == KW_START) begin
      r = (b == "u") ? KW_USE_FIRST : (b == "p") ? KW_PRINT_FIRST :
          (b == "i") ? KW_INPUT_FIRST : KW_DEAD;
    end else if (e != 8'h00 && e == b) begin
      r = k + 4'd1;
    end else begin
      r = KW_DEAD;
    end
    return r;
  endfunction

  function automatic shape_e ns_next(input shape_e s, input logic [7:0] b);
    logic   digit;
    shape_e r;
    digit = (b >= "0") && (b <= "9");
    unique case (s)
      NS_START:        r = digit ? NS_INT : NS_DEAD;
      NS_INT:          r = digit ? NS_INT : ((b == ".") ? NS_DOT : NS_DEAD);
      NS_DOT, NS_FRAC: r = digit ? NS_FRAC : NS_DEAD;
      default:         r = NS_DEAD;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || b == CH_HT || b == CH_CR || b == CH_VT || b == CH_FF;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    logic op;
    op = b == "+" || b == "-" || b == "*" || b == "/" || b == "%" || b == ">" ||
         b == "<" || b == "=" || b == "!" || b == "[" || b == "]" || b == "(" ||
         b == ")" || b == ";" || b == "," || b == ":";
    return !(is_space(b) || b == CH_LF || op);
  endfunction

  function automatic logic [TOKEN_BITS-1:0] make_tok(
    input slb_pkg::token_kind_e   kind,
    input logic [OFFSET_BITS-1:0] start,
    input logic [LENGTH_BITS-1:0] len,
    input logic [LINE_BITS-1:0]   line
  );
    return {1'b1, kind, start, len, line};
  endfunction

  // Close a held token as it stands.
  function automatic logic [TOKEN_BITS-1:0] flush_tok(
    input pend_e                  p,
    input logic [3:0]             kp,
    input shape_e                 ns,
    input logic [LENGTH_BITS-1:0] len,
    input logic [OFFSET_BITS-1:0] start,
    input logic [LINE_BITS-1:0]   line
  );
    slb_pkg::token_kind_e   kind;
    logic [TOKEN_BITS-1:0]  t;
    logic [LENGTH_BITS-1:0] one;
    one = LENGTH_BITS'(1);
    t   = '0;
    unique case (p)
      PEND_WORD: begin
        if (kp == KW_USE_DONE || kp == KW_PRINT_DONE || kp == KW_INPUT_DONE) begin
          kind = slb_pkg::KIND_METHOD;
        end else if (ns == NS_INT || ns == NS_FRAC) begin
          kind = slb_pkg::KIND_NUMBER;
        end else begin
          kind = slb_pkg::KIND_OTHER;
        end
        t = make_tok(kind, start, len, line);
      end
      PEND_GT, PEND_LT:      t = make_tok(slb_pkg::KIND_CONDITION, start, one, line);
      PEND_EQ:               t = make_tok(slb_pkg::KIND_ASSIGN, start, one, line);
      PEND_MINUS, PEND_STAR: t = make_tok(slb_pkg::KIND_OPERATOR, start, one, line);
      default:               t = '0;
    endcase
    return t;
  endfunction

  pend_e                  pend_q, pend_n, pend_d;
  logic [OFFSET_BITS-1:0] start_q, start_n, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_n, len_d, len_inc;
  logic [3:0]             kp_q, kp_n, kp_d;
  shape_e                 ns_q, ns_n, ns_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [LINE_BITS-1:0]   line_q, line_n, line_d;
  logic                   consumed;
  logic                   accept;
  logic [TOKEN_BITS-1:0]  tok_a, tok_b, tok_c;

  assign accept  = in_valid_i && !full_i;
  assign len_inc = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);
  assign pos_inc = pos_q + OFFSET_BITS'(1);

  always_comb begin
    consumed = 1'b0;
    tok_a    = '0;
    tok_b    = '0;
    tok_c    = '0;
    pend_n   = pend_q;
    start_n  = start_q;
    len_n    = len_q;
    kp_n     = kp_q;
    ns_n     = ns_q;
    line_n   = line_q;

    // Try to extend the held token with this byte.
    unique case (pend_q)
      PEND_WORD: begin
        if (is_word(code_byte_i)) begin
          consumed = 1'b1;
          kp_n     = kw_next(kp_q, code_byte_i);
          ns_n     = ns_next(ns_q, code_byte_i);
          len_n    = len_inc;
        end
      end
      PEND_GT, PEND_LT, PEND_EQ, PEND_BANG: begin
        if (code_byte_i == "=") begin
          consumed = 1'b1;
          tok_a    = make_tok(slb_pkg::KIND_CONDITION, start_q, LENGTH_BITS'(2), line_q);
        end
      end
      PEND_MINUS: begin
        if (code_byte_i == ">") begin
          consumed = 1'b1;
          tok_a    = make_tok(slb_pkg::KIND_ASSIGN, start_q, LENGTH_BITS'(2), line_q);
        end
      end
      PEND_STAR: begin
        if (code_byte_i == "*") begin
          consumed = 1'b1;
          tok_a    = make_tok(slb_pkg::KIND_OPERATOR, start_q, LENGTH_BITS'(2), line_q);
        end
      end
      default: ;
    endcase

    if (consumed && pend_q != PEND_WORD) begin
      pend_n  = PEND_NONE;
      start_n = '0;
      len_n   = '0;
      kp_n    = KW_START;
      ns_n    = NS_START;
    end

    if (!consumed) begin
      tok_a   = flush_tok(pend_q, kp_q, ns_q, len_q, start_q, line_q);
      pend_n  = PEND_NONE;
      start_n = '0;
      len_n   = '0;
      kp_n    = KW_START;
      ns_n    = NS_START;
      unique case (code_byte_i)
        CH_LF: begin
          tok_b  = make_tok(slb_pkg::KIND_LINE_END, pos_q, LENGTH_BITS'(1), line_q);
          line_n = (&line_q) ? line_q : line_q + LINE_BITS'(1);
        end
        "[", "]", "(", ")", ";", ",":
          tok_b = make_tok(slb_pkg::KIND_SEPARATOR, pos_q, LENGTH_BITS'(1), line_q);
        ":":
          tok_b = make_tok(slb_pkg::KIND_ASSIGN, pos_q, LENGTH_BITS'(1), line_q);
        "+", "/", "%":
          tok_b = make_tok(slb_pkg::KIND_OPERATOR, pos_q, LENGTH_BITS'(1), line_q);
        ">": begin pend_n = PEND_GT;    start_n = pos_q; end
        "<": begin pend_n = PEND_LT;    start_n = pos_q; end
        "=": begin pend_n = PEND_EQ;    start_n = pos_q; end
        "!": begin pend_n = PEND_BANG;  start_n = pos_q; end
        "-": begin pend_n = PEND_MINUS; start_n = pos_q; end
        "*": begin pend_n = PEND_STAR;  start_n = pos_q; end
        " ", CH_HT, CH_CR, CH_VT, CH_FF: ;
        default: begin
          pend_n  = PEND_WORD;
          start_n = pos_q;
          len_n   = LENGTH_BITS'(1);
          kp_n    = kw_next(KW_START, code_byte_i);
          ns_n    = ns_next(NS_START, code_byte_i);
        end
      endcase
    end

    pend_d  = pend_n;
    start_d = start_n;
    len_d   = len_n;
    kp_d    = kp_n;
    ns_d    = ns_n;
    pos_d   = pos_inc;
    line_d  = line_n;

    // Final byte: close whatever is held, report code end, drop all state.
    if (end_of_code_i) begin
      if (!tok_b[TOKEN_BITS-1]) begin
        tok_b = flush_tok(pend_n, kp_n, ns_n, len_n, start_n, line_q);
      end
      tok_c   = make_tok(slb_pkg::KIND_CODE_END, pos_inc, '0, line_n);
      pend_d  = PEND_NONE;
      start_d = '0;
      len_d   = '0;
      kp_d    = KW_START;
      ns_d    = NS_START;
      pos_d   = '0;
      line_d  = '0;
    end
  end

  assign push_o   = accept &&
                    (tok_a[TOKEN_BITS-1] || tok_b[TOKEN_BITS-1] || tok_c[TOKEN_BITS-1]);
  assign bundle_o = {tok_c, tok_b, tok_a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PEND_NONE;
      start_q <= '0;
      len_q   <= '0;
      kp_q    <= KW_START;
      ns_q    <= NS_START;
      pos_q   <= '0;
      line_q  <= '0;
    end else if (accept) begin
      pend_q  <= pend_d;
      start_q <= start_d;
      len_q   <= len_d;
      kp_q    <= kp_d;
      ns_q    <= ns_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

// File: design/slb_fifo.sv
// Token bundle queue between the lexer front end and the output stage.
// Small flop array with read and write pointers; depth from slb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = slb_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o  = count_q == CNT_BITS'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_BITS'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_BITS'(1);
        2'b01:   count_q <= count_q - CNT_BITS'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/slb_back.sv
// Output stage: walks the valid slots of the head bundle, one token per
// transaction, into a registered output. Depends on slb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slb_back #(
  parameter int unsigned OFFSET_BITS = slb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = slb_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = slb_pkg::LINE_BITS_DEF,
  localparam int unsigned TOKEN_BITS =
    1 + slb_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   head_valid_i,
  input  wire logic [slb_pkg::SLOT_COUNT*TOKEN_BITS-1:0] head_i,
  output logic                                        pop_o,
  input  wire logic                                   out_stall_i,
  output logic                                        out_valid_o,
  output logic [slb_pkg::KIND_BITS-1:0]               token_kind_o,
  output logic [OFFSET_BITS-1:0]                      start_offset_o,
  output logic [LENGTH_BITS-1:0]                      token_length_o,
  output logic [LINE_BITS-1:0]                        line_number_o,
  output logic                                        run_end_o
);

  localparam int unsigned SLOTS    = slb_pkg::SLOT_COUNT;
  localparam int unsigned SEL_BITS = $clog2(SLOTS);
  localparam int unsigned LEN_LSB  = LINE_BITS;
  localparam int unsigned POS_LSB  = LINE_BITS + LENGTH_BITS;
  localparam int unsigned KIND_LSB = POS_LSB + OFFSET_BITS;

  logic [SLOTS-1:0]                done_q, slot_valid, remaining, sel_oh;
  logic [SEL_BITS-1:0]             sel_idx;
  logic [TOKEN_BITS-1:0]           tok;
  logic                            last_slot, load;
  logic                            out_valid_q, run_end_q;
  logic [slb_pkg::KIND_BITS-1:0]   kind_q;
  logic [OFFSET_BITS-1:0]          start_q;
  logic [LENGTH_BITS-1:0]          length_q;
  logic [LINE_BITS-1:0]            line_q;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_valid[k] = head_i[k*TOKEN_BITS + TOKEN_BITS - 1];
    end
    remaining = slot_valid & ~done_q;
    // Lowest remaining slot goes out first.
    sel_oh    = remaining & (~remaining + SLOTS'(1));
    sel_idx   = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (sel_oh[k]) begin
        sel_idx = SEL_BITS'(k);
      end
    end
    tok       = head_i[sel_idx*TOKEN_BITS +: TOKEN_BITS];
    last_slot = (remaining & ~sel_oh) == '0;
  end

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      done_q      <= last_slot ? '0 : (done_q | sel_oh);
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= tok[KIND_LSB +: slb_pkg::KIND_BITS];
      start_q   <= tok[POS_LSB +: OFFSET_BITS];
      length_q  <= tok[LEN_LSB +: LENGTH_BITS];
      line_q    <= tok[LINE_BITS-1:0];
      run_end_q <= last_slot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign start_offset_o = start_q;
  assign token_length_o = length_q;
  assign line_number_o  = line_q;
  assign run_end_o      = run_end_q;

endmodule

`default_nettype wire

// File: design/script_lexer_byte_stream.sv
// Byte-stream lexer: takes one source byte per transaction and reports tokens
// (kind, start offset, length, line) one per transaction on the output side.
// Any byte may be accepted in the cycle after the previous one while the queue
// is not full; the front end turns each byte into a bundle of zero to three
// tokens in that same cycle and writes any nonempty bundle into a four-entry
// bundle queue, and the output register drains one token per cycle while the
// output is not stalled. A byte's tokens pass through the bundle queue and then
// the output register. Sustained input is one byte per cycle while bytes average
// no more than one token each and the output is not stalled; input stalls only
// when the queue is full. No clearing pass after reset.
// Depends on slb_pkg, slb_front, slb_fifo and slb_back.
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_byte_stream #(
  parameter int unsigned OFFSET_BITS = slb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = slb_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = slb_pkg::LINE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    code_byte_i,
  input  wire logic                          end_of_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [slb_pkg::KIND_BITS-1:0]      token_kind_o,
  output logic [OFFSET_BITS-1:0]             start_offset_o,
  output logic [LENGTH_BITS-1:0]             token_length_o,
  output logic [LINE_BITS-1:0]               line_number_o,
  output logic                               run_end_o
);

  localparam int unsigned TOKEN_BITS =
    1 + slb_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
  localparam int unsigned BUNDLE_BITS = slb_pkg::SLOT_COUNT * TOKEN_BITS;

  logic                   push, pop, fifo_full, head_valid;
  logic [BUNDLE_BITS-1:0] bundle, head;

  assign in_stall_o = fifo_full;

  slb_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .code_byte_i   (code_byte_i),
    .end_of_code_i (end_of_code_i),
    .full_i        (fifo_full),
    .push_o        (push),
    .bundle_o      (bundle)
  );

  slb_fifo #(
    .WIDTH (BUNDLE_BITS),
    .DEPTH (slb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (head_valid),
    .data_o  (head)
  );

  slb_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .run_end_o      (run_end_o)
  );

`ifndef SYNTH
  a_code_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == slb_pkg::KIND_CODE_END |->
      run_end_o && token_length_o == '0)
    else $error("code end token not last of its run or nonzero length");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("bundle popped from empty queue");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !push)
    else $error("bundle pushed into full queue");
`endif

endmodule

`default_nettype wire
